[design/csim_pkg.sv]
package csim_pkg;

  localparam int unsigned MaxElementsDef = 32;
  localparam int unsigned FracBits       = 15;

  typedef enum logic [2:0] {
    BkIdle,
    BkMul,
    BkSqrt,
    BkDiv,
    BkOut
  } back_state_e;

endpackage

[design/csim_front.sv]
module csim_front #(
  parameter int unsigned MAX_ELEMENTS = csim_pkg::MaxElementsDef,
  parameter int unsigned AW = 36,
  parameter int unsigned DW = 37
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [15:0]   a_value_i,
  input  logic signed [15:0]   b_value_i,
  input  logic                 last_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [DW+2*AW-1:0]   entry_o
);

  localparam logic [AW:0] BoundX = (AW+1)'(MAX_ELEMENTS) << 30;

  logic signed [DW-1:0] dot_q, dot_d;
  logic [AW-1:0]        na_q, na_d, nb_q, nb_d;
  logic signed [31:0]   prod_ab, prod_aa, prod_bb;
  logic signed [DW:0]   dot_ext, pos_bound, neg_bound;
  logic [AW:0]          na_ext, nb_ext;
  logic signed [DW-1:0] dot_new;
  logic [AW-1:0]        na_new, nb_new;
  logic                 accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  assign prod_ab = a_value_i * b_value_i;
  assign prod_aa = a_value_i * a_value_i;
  assign prod_bb = b_value_i * b_value_i;

  assign pos_bound = $signed({1'b0, BoundX});
  assign neg_bound = -pos_bound;

  always_comb begin
    dot_ext = {dot_q[DW-1], dot_q} + (DW+1)'(prod_ab);
    na_ext  = {1'b0, na_q} + (AW+1)'(prod_aa[30:0]);
    nb_ext  = {1'b0, nb_q} + (AW+1)'(prod_bb[30:0]);

    // The sums clamp at the bound rather than wrap.
    if (dot_ext > pos_bound) begin
      dot_new = pos_bound[DW-1:0];
    end else if (dot_ext < neg_bound) begin
      dot_new = neg_bound[DW-1:0];
    end else begin
      dot_new = dot_ext[DW-1:0];
    end
    na_new = (na_ext > BoundX) ? BoundX[AW-1:0] : na_ext[AW-1:0];
    nb_new = (nb_ext > BoundX) ? BoundX[AW-1:0] : nb_ext[AW-1:0];

    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    if (accept) begin
      if (last_i) begin
        dot_d = '0;
        na_d  = '0;
        nb_d  = '0;
      end else begin
        dot_d = dot_new;
        na_d  = na_new;
        nb_d  = nb_new;
      end
    end
  end

  assign push_o  = accept && last_i;
  assign entry_o = {dot_new, na_new, nb_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else begin
      dot_q <= dot_d;
      na_q  <= na_d;
      nb_q  <= nb_d;
    end
  end

endmodule

[design/csim_fifo.sv]
module csim_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[design/csim_back.sv]
module csim_back #(
  parameter int unsigned AW = 36,
  parameter int unsigned DW = 37
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  logic [DW+2*AW-1:0]  entry_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [15:0]         similarity_o,
  output logic                zero_norm_o
);

  localparam int unsigned PW = 2 * AW;
  localparam int unsigned NW = AW + csim_pkg::FracBits;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [NW-1:0] MaxPos = NW'(32767);
  localparam logic [NW-1:0] MaxNeg = NW'(32768);

  csim_pkg::back_state_e state_q, state_d;

  logic signed [DW-1:0] dot_q, dot_d;
  logic [PW-1:0]        ma_q, ma_d, prod_q, prod_d;
  logic [AW-1:0]        mb_q, mb_d, root_q, root_d;
  logic [AW+1:0]        srem_q, srem_d, srem_t, trial;
  logic [AW:0]          drem_q, drem_d, drem_t;
  logic [NW-1:0]        num_q, num_d, quo_q, quo_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [15:0]          sim_q, sim_d;
  logic                 zero_q, zero_d;
  logic signed [DW-1:0] e_dot;
  logic [AW-1:0]        e_na, e_nb, mag;
  logic signed [DW-1:0] dot_abs;

  assign e_dot = entry_i[DW+2*AW-1:2*AW];
  assign e_na  = entry_i[2*AW-1:AW];
  assign e_nb  = entry_i[AW-1:0];

  assign valid_o      = (state_q == csim_pkg::BkOut);
  assign similarity_o = sim_q;
  assign zero_norm_o  = zero_q;

  assign dot_abs = dot_q[DW-1] ? -dot_q : dot_q;
  assign mag     = dot_abs[AW-1:0];
  assign srem_t  = {srem_q[AW-1:0], prod_q[PW-1:PW-2]};
  assign trial   = {root_q, 2'b01};
  assign drem_t  = {drem_q[AW-1:0], num_q[NW-1]};

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    dot_d   = dot_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    prod_d  = prod_q;
    root_d  = root_q;
    srem_d  = srem_q;
    drem_d  = drem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    sim_d   = sim_q;
    zero_d  = zero_q;

    unique case (state_q)
      csim_pkg::BkIdle: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          dot_d  = e_dot;
          ma_d   = PW'(e_na);
          mb_d   = e_nb;
          prod_d = '0;
          cnt_d  = CW'(AW);
          if (e_na == '0 || e_nb == '0) begin
            sim_d   = '0;
            zero_d  = 1'b1;
            state_d = csim_pkg::BkOut;
          end else begin
            state_d = csim_pkg::BkMul;
          end
        end
      end
      csim_pkg::BkMul: begin
        // Shift-and-add product of the two squared norms.
        if (cnt_q == '0) begin
          root_d  = '0;
          srem_d  = '0;
          cnt_d   = CW'(AW);
          state_d = csim_pkg::BkSqrt;
        end else begin
          if (mb_q[0]) begin
            prod_d = prod_q + ma_q;
          end
          ma_d  = ma_q << 1;
          mb_d  = mb_q >> 1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      csim_pkg::BkSqrt: begin
        // Digit-by-digit root, two radicand bits per step.
        if (cnt_q == '0) begin
          num_d   = {mag, {csim_pkg::FracBits{1'b0}}};
          drem_d  = '0;
          quo_d   = '0;
          cnt_d   = CW'(NW);
          state_d = csim_pkg::BkDiv;
        end else begin
          if (srem_t >= trial) begin
            srem_d = srem_t - trial;
            root_d = {root_q[AW-2:0], 1'b1};
          end else begin
            srem_d = srem_t;
            root_d = {root_q[AW-2:0], 1'b0};
          end
          prod_d = prod_q << 2;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      csim_pkg::BkDiv: begin
        // Restoring division, one quotient bit per step.
        if (cnt_q == '0) begin
          zero_d = 1'b0;
          if (dot_q[DW-1]) begin
            sim_d = (quo_q > MaxNeg) ? 16'h8000 : 16'(-quo_q[15:0]);
          end else begin
            sim_d = (quo_q > MaxPos) ? 16'h7fff : quo_q[15:0];
          end
          state_d = csim_pkg::BkOut;
        end else begin
          if (drem_t >= {1'b0, root_q}) begin
            drem_d = drem_t - {1'b0, root_q};
            quo_d  = {quo_q[NW-2:0], 1'b1};
          end else begin
            drem_d = drem_t;
            quo_d  = {quo_q[NW-2:0], 1'b0};
          end
          num_d = num_q << 1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      csim_pkg::BkOut: begin
        if (ready_i) begin
          state_d = csim_pkg::BkIdle;
        end
      end
      default: begin
        state_d = csim_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csim_pkg::BkIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q  <= dot_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    prod_q <= prod_d;
    root_q <= root_d;
    srem_q <= srem_d;
    drem_q <= drem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    sim_q  <= sim_d;
    zero_q <= zero_d;
  end

endmodule

[design/cosine_similarity_unit.sv]
// Inputs are taken one per cycle while the queue is not full; the accumulators keep
// pace with the stream. Each vector's result is formed by the bit-serial multiplier,
// root and divider of the back end (AW = clog2(MAX_ELEMENTS+1) + 30); a two-entry queue
// lets the front keep streaming while up to two vectors wait there.
// Asynchronous active-low reset clears the accumulators, queue and sequencer.
module cosine_similarity_unit #(
  parameter int unsigned MAX_ELEMENTS = csim_pkg::MaxElementsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // a_value [15:0], b_value [31:16]
  input  logic        s_axis_tlast_i,  // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // similarity [15:0], zero_norm [16], zeros above
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS + 1) + 30;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned EW = DW + 2 * AW;

  logic          full, empty, push, pop, zero_norm;
  logic [EW-1:0] wr_entry, rd_entry;
  logic [15:0]   similarity;

  csim_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .AW(AW),
    .DW(DW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .a_value_i(s_axis_tdata_i[15:0]),
    .b_value_i(s_axis_tdata_i[31:16]),
    .last_i   (s_axis_tlast_i),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (wr_entry)
  );

  csim_fifo #(
    .W(EW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wr_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (rd_entry)
  );

  csim_back #(
    .AW(AW),
    .DW(DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (rd_entry),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .similarity_o(similarity),
    .zero_norm_o (zero_norm)
  );

  assign m_axis_tdata_o = {7'd0, zero_norm, similarity};

endmodule
